// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the text console cursor engine.
// Each macro takes a label, the clock and the expressions; ASSERT_SAME also takes the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tcce_pkg.sv =====
// Package of the text console cursor engine: codes, reset values and types.
// Used by every module; depends on nothing.
package tcce_pkg;

    localparam logic [7:0] CodeNewline   = 8'd13;
    localparam logic [7:0] CodeBackspace = 8'd8;
    localparam logic [7:0] GlyphSpace    = 8'd32;

    localparam logic [7:0] ColumnCountReset  = 8'd80;
    localparam logic [7:0] RowCountReset     = 8'd24;
    localparam logic [7:0] LeftMarginReset   = 8'd0;
    localparam logic [7:0] RightMarginReset  = 8'd0;
    localparam logic [7:0] ScrollTopRowReset = 8'd0;

    localparam int QueueDepthDefault = 2;
    localparam int CfgIndexWidth     = 3;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_COLUMN_COUNT   = 3'd0,
        CFG_ROW_COUNT      = 3'd1,
        CFG_LEFT_MARGIN    = 3'd2,
        CFG_RIGHT_MARGIN   = 3'd3,
        CFG_SCROLL_TOP_ROW = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        ACT_MOVE   = 2'd0,
        ACT_DRAW   = 2'd1,
        ACT_SCROLL = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        OP_NEWLINE   = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_DRAW      = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] code;
    } t_op;

    typedef struct packed {
        logic [7:0] column_count;
        logic [7:0] row_count;
        logic [7:0] left_margin;
        logic [7:0] right_margin;
        logic [7:0] scroll_top_row;
    } t_cfg;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] column;
    } t_pos;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_q_handshake;

endpackage

// ===== rtl/tcce_in_if.sv =====
// Input channel of the text console cursor engine: one character code per word.
// Depends on nothing but the clocking of the modules that use it.
interface tcce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/tcce_out_if.sv =====
// Result channel of the text console cursor engine: one screen action per word.
// Depends on nothing but the clocking of the modules that use it.
interface tcce_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] draw_row;
    logic [7:0] draw_column;
    logic [7:0] glyph;
    logic [7:0] cursor_row;
    logic [7:0] cursor_column;
    logic       last;

    modport source (output valid, output action, output draw_row, output draw_column,
                    output glyph, output cursor_row, output cursor_column, output last,
                    input ready);
    modport sink (input valid, input action, input draw_row, input draw_column,
                  input glyph, input cursor_row, input cursor_column, input last,
                  output ready);
endinterface

// ===== rtl/tcce_front.sv =====
// Front stage: accepts character words, classifies them and offers them to the queue.
// Depends on tcce_pkg and tcce_in_if.
module tcce_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    tcce_in_if.sink                 i_in,
    output tcce_pkg::t_op           o_op,
    output tcce_pkg::t_q_handshake  o_push,
    input  logic                    i_q_ready
);

    logic          r_valid;
    tcce_pkg::t_op r_op;
    tcce_pkg::t_op n_op;
    logic          w_take;

    assign i_in.ready = !r_valid || i_q_ready;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        n_op.code = i_in.char_code;
        unique case (i_in.char_code)
            tcce_pkg::CodeNewline:   n_op.kind = tcce_pkg::OP_NEWLINE;
            tcce_pkg::CodeBackspace: n_op.kind = tcce_pkg::OP_BACKSPACE;
            default:                 n_op.kind = tcce_pkg::OP_DRAW;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op <= n_op;
        end
    end

    assign o_op         = r_op;
    assign o_push.valid = r_valid;
    assign o_push.ready = i_q_ready;

endmodule

// ===== rtl/tcce_queue.sv =====
// Short first-in first-out queue of classified operations between front and back.
// Depends on tcce_pkg.
module tcce_queue #(
    parameter int Depth = tcce_pkg::QueueDepthDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tcce_pkg::t_op           i_op,
    input  logic                    i_push,
    output logic                    o_ready,
    output tcce_pkg::t_op           o_op,
    output logic                    o_valid,
    input  logic                    i_pop
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    tcce_pkg::t_op   r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_ready = r_count != CntW'(Depth);
    assign o_valid = r_count != '0;
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tcce_back.sv =====
// Back stage: holds the cursor and turns each queued operation into action words.
// Depends on tcce_pkg and tcce_out_if.
module tcce_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tcce_pkg::t_cfg  i_cfg,
    input  tcce_pkg::t_op   i_op,
    input  logic            i_op_valid,
    output logic            o_pop,
    tcce_out_if.source      o_out
);

    logic [7:0]       r_cur_row;
    logic [7:0]       r_cur_col;
    logic             r_phase;
    logic             r_out_valid;
    tcce_pkg::t_action r_action;
    logic [7:0]       r_draw_row;
    logic [7:0]       r_draw_col;
    logic [7:0]       r_glyph;
    logic [7:0]       r_out_row;
    logic [7:0]       r_out_col;
    logic             r_last;

    logic             n_phase;
    tcce_pkg::t_pos   n_pos;
    tcce_pkg::t_action n_action;
    logic [7:0]       n_draw_row;
    logic [7:0]       n_draw_col;
    logic [7:0]       n_glyph;
    logic             n_last;

    tcce_pkg::t_pos   w_cur;
    tcce_pkg::t_pos   w_back;
    tcce_pkg::t_pos   w_nl;
    logic             w_scroll;
    logic             w_fire;

    function automatic tcce_pkg::t_pos step_back(tcce_pkg::t_pos p, tcce_pkg::t_cfg c);
        tcce_pkg::t_pos q;
        q = p;
        if (p.column > c.left_margin) begin
            q.column = p.column - 8'd1;
        end else if (p.row != 8'd0) begin
            q.column = c.column_count - c.right_margin - 8'd1;
            q.row    = p.row - 8'd1;
        end
        return q;
    endfunction

    assign w_fire = i_op_valid && (!r_out_valid || o_out.ready);
    assign w_cur  = '{row: r_cur_row, column: r_cur_col};
    assign w_back = step_back(w_cur, i_cfg);

    always_comb begin
        w_scroll  = !(({1'b0, r_cur_row} + 9'd1) < {1'b0, i_cfg.row_count});
        w_nl.column = i_cfg.left_margin;
        w_nl.row    = w_scroll ? r_cur_row : r_cur_row + 8'd1;
    end

    always_comb begin
        n_pos      = w_cur;
        n_phase    = r_phase;
        n_action   = tcce_pkg::ACT_MOVE;
        n_draw_row = 8'd0;
        n_draw_col = 8'd0;
        n_glyph    = 8'd0;
        n_last     = 1'b0;
        o_pop      = 1'b0;
        if (w_fire) begin
            unique case (i_op.kind)
                tcce_pkg::OP_NEWLINE: begin
                    n_pos  = w_nl;
                    n_last = 1'b1;
                    o_pop  = 1'b1;
                    if (w_scroll) begin
                        n_action   = tcce_pkg::ACT_SCROLL;
                        n_draw_row = i_cfg.scroll_top_row;
                    end
                end
                tcce_pkg::OP_BACKSPACE: begin
                    n_pos = w_back;
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        if (w_back.column < i_cfg.column_count) begin
                            n_action   = tcce_pkg::ACT_DRAW;
                            n_draw_row = w_back.row;
                            n_draw_col = w_back.column;
                            n_glyph    = tcce_pkg::GlyphSpace;
                            n_pos.column = w_back.column + 8'd1;
                        end
                    end else begin
                        n_phase = 1'b0;
                        n_last  = 1'b1;
                        o_pop   = 1'b1;
                    end
                end
                tcce_pkg::OP_DRAW: begin
                    if (!r_phase && (r_cur_col >= i_cfg.column_count)) begin
                        n_phase = 1'b1;
                        n_pos   = w_nl;
                        if (w_scroll) begin
                            n_action   = tcce_pkg::ACT_SCROLL;
                            n_draw_row = i_cfg.scroll_top_row;
                        end
                    end else begin
                        n_phase = 1'b0;
                        n_last  = 1'b1;
                        o_pop   = 1'b1;
                        if (r_cur_col < i_cfg.column_count) begin
                            n_action     = tcce_pkg::ACT_DRAW;
                            n_draw_row   = r_cur_row;
                            n_draw_col   = r_cur_col;
                            n_glyph      = i_op.code;
                            n_pos.column = r_cur_col + 8'd1;
                        end else begin
                            n_pos.column = i_cfg.column_count;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row   <= 8'd0;
            r_cur_col   <= 8'd0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_cur_row   <= n_pos.row;
                r_cur_col   <= n_pos.column;
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_action   <= n_action;
            r_draw_row <= n_draw_row;
            r_draw_col <= n_draw_col;
            r_glyph    <= n_glyph;
            r_out_row  <= n_pos.row;
            r_out_col  <= n_pos.column;
            r_last     <= n_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.action        = r_action;
    assign o_out.draw_row      = r_draw_row;
    assign o_out.draw_column   = r_draw_col;
    assign o_out.glyph         = r_glyph;
    assign o_out.cursor_row    = r_out_row;
    assign o_out.cursor_column = r_out_col;
    assign o_out.last          = r_last;

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: configuration registers and wiring.
// Depends on tcce_pkg, tcce_in_if, tcce_out_if, tcce_front, tcce_queue, tcce_back.
//
// Usage: each input word on i_in carries one character code. Code 13 starts a new
// line, code 8 erases the cell behind the cursor, every other code is drawn at the
// cursor. Each input word yields one or two result words on o_out, and the final
// one of an input carries last. Results give the action, the cell that was drawn
// and the cursor position after the action, in character coordinates.
// The input word passes through the front register and the queue, after which the
// back stage registers its result. The back stage emits one result word per cycle
// while the receiver takes them, and holds an input until its last result word is
// issued; the front stage and the queue take a new input word every cycle while
// there is room.
// Configuration writes on i_cfg_we are taken at any edge and are meant for idle.
// Reset sets the registers to 80 columns, 24 rows and zero margins and split row,
// and places the cursor at row 0, column 0. A stalled receiver holds the result
// word in the output register; the queue fills and then i_in.ready goes low.
`include "assert_macros.svh"

module text_console_cursor_engine #(
    parameter int QueueDepth = tcce_pkg::QueueDepthDefault
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    tcce_in_if.sink                            i_in,
    tcce_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [tcce_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [7:0]                         i_cfg_data
);

    tcce_pkg::t_cfg         r_cfg;
    tcce_pkg::t_op          w_front_op;
    tcce_pkg::t_q_handshake w_push;
    logic                   w_q_ready;
    tcce_pkg::t_op          w_head_op;
    logic                   w_head_valid;
    logic                   w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_count   <= tcce_pkg::ColumnCountReset;
            r_cfg.row_count      <= tcce_pkg::RowCountReset;
            r_cfg.left_margin    <= tcce_pkg::LeftMarginReset;
            r_cfg.right_margin   <= tcce_pkg::RightMarginReset;
            r_cfg.scroll_top_row <= tcce_pkg::ScrollTopRowReset;
        end else if (i_cfg_we) begin
            unique case (tcce_pkg::t_cfg_index'(i_cfg_index))
                tcce_pkg::CFG_COLUMN_COUNT:   r_cfg.column_count   <= i_cfg_data;
                tcce_pkg::CFG_ROW_COUNT:      r_cfg.row_count      <= i_cfg_data;
                tcce_pkg::CFG_LEFT_MARGIN:    r_cfg.left_margin    <= i_cfg_data;
                tcce_pkg::CFG_RIGHT_MARGIN:   r_cfg.right_margin   <= i_cfg_data;
                tcce_pkg::CFG_SCROLL_TOP_ROW: r_cfg.scroll_top_row <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    tcce_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_op      (w_front_op),
        .o_push    (w_push),
        .i_q_ready (w_q_ready)
    );

    tcce_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_front_op),
        .i_push  (w_push.valid && w_push.ready),
        .o_ready (w_q_ready),
        .o_op    (w_head_op),
        .o_valid (w_head_valid),
        .i_pop   (w_pop)
    );

    tcce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op       (w_head_op),
        .i_op_valid (w_head_valid),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

    `ASSERT_SAME(a_draw_advances, i_clk, i_rst_n,
        o_out.valid && (o_out.action == tcce_pkg::ACT_DRAW),
        (o_out.cursor_column == 8'(o_out.draw_column + 8'd1)))
    `ASSERT_SAME(a_scroll_fields, i_clk, i_rst_n,
        o_out.valid && (o_out.action == tcce_pkg::ACT_SCROLL),
        (o_out.draw_row == r_cfg.scroll_top_row) &&
        (o_out.cursor_column == r_cfg.left_margin) && (o_out.glyph == 8'd0))
    `ASSERT_NEXT(a_reset_empties, i_clk, !i_rst_n, !o_out.valid && !w_head_valid)

endmodule
